// File: design/wvs_pkg.sv
// ----------------------------------------------------------------------------
// wvs_pkg
// Shared types and codes for the wire value serializer: the request and
// response payloads, the encoding selector codes and the control interface.
// ----------------------------------------------------------------------------
`default_nettype none

package wvs_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 7;
  localparam int unsigned CountW = 4;

  typedef enum logic [2:0] {
    FuncFixed8  = 3'd0,
    FuncFixed16 = 3'd1,
    FuncFixed32 = 3'd2,
    FuncFixed64 = 3'd3,
    FuncBool    = 3'd4,
    FuncVarint  = 3'd5,
    FuncZigzag  = 3'd6,
    FuncUnused  = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [ValueW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } out_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
    logic last_byte;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/wvs_datapath.sv
// ----------------------------------------------------------------------------
// wvs_datapath
// Holds the value being encoded, shifts out one byte or one 7-bit group per
// emit command and keeps the output register toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wvs_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wvs_pkg::in_req_t    in_req_i,
  input  wire wvs_pkg::dp_cmd_t    cmd_i,
  output wvs_pkg::dp_status_t      status_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wvs_pkg::out_rsp_t        out_rsp_o
);
  import wvs_pkg::*;

  logic [ValueW-1:0] val_q, val_d;
  logic              varint_q, varint_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  out_rsp_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [ValueW-1:0] load_val;
  logic              load_varint;
  logic [CountW-1:0] load_cnt;
  logic              last_byte;
  logic [ByteW-1:0]  next_byte;

  always_comb begin
    load_val    = in_req_i.value;
    load_varint = 1'b0;
    load_cnt    = CountW'(1);
    case (func_e'(in_req_i.func))
      FuncFixed8:  load_cnt = CountW'(1);
      FuncFixed16: load_cnt = CountW'(2);
      FuncFixed32: load_cnt = CountW'(4);
      FuncFixed64: load_cnt = CountW'(8);
      FuncBool: begin
        load_val = {{(ValueW-1){1'b0}}, |in_req_i.value};
      end
      FuncVarint: load_varint = 1'b1;
      FuncZigzag: begin
        load_varint = 1'b1;
        load_val    = {in_req_i.value[ValueW-2:0], 1'b0} ^ {ValueW{in_req_i.value[ValueW-1]}};
      end
      default: ;
    endcase
  end

  // A varint group is the last one once nothing remains above its seven bits.
  always_comb begin
    if (varint_q) begin
      last_byte = (val_q[ValueW-1:GroupW] == '0);
      next_byte = {~last_byte, val_q[GroupW-1:0]};
    end else begin
      last_byte = (cnt_q == CountW'(1));
      next_byte = val_q[ByteW-1:0];
    end
  end

  always_comb begin
    val_d       = val_q;
    varint_d    = varint_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.load) begin
      val_d    = load_val;
      varint_d = load_varint;
      cnt_d    = load_cnt;
    end else if (cmd_i.emit) begin
      out_d.out_byte = next_byte;
      out_d.last     = last_byte;
      out_valid_d    = 1'b1;
      cnt_d          = cnt_q - CountW'(1);
      val_d          = varint_q ? (val_q >> GroupW) : (val_q >> ByteW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    varint_q <= varint_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign status_o.slot_free = ~out_valid_q | ~out_stall_i;
  assign status_o.last_byte = last_byte;
  assign out_valid_o        = out_valid_q;
  assign out_rsp_o          = out_q;

endmodule

`default_nettype wire

// File: design/wvs_ctrl.sv
// ----------------------------------------------------------------------------
// wvs_ctrl
// Sequencer: takes a request while idle, then issues one emit per cycle in
// which the output register can take a byte, until the last byte is out.
// ----------------------------------------------------------------------------
`default_nettype none

module wvs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [2:0]          in_func_i,
  output logic                     in_stall_o,
  input  wire wvs_pkg::dp_status_t status_i,
  output wvs_pkg::dp_cmd_t         cmd_o
);
  import wvs_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StSend = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    case (state_q)
      StIdle: begin
        // The unused selector is taken and produces nothing.
        if (accept && (func_e'(in_func_i) != FuncUnused)) begin
          cmd_o.load = 1'b1;
          state_d    = StSend;
        end
      end
      StSend: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_byte) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == StSend) && status_i.slot_free)
    else $error("emit issued without a free output slot");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && status_i.last_byte |=> state_q == StIdle)
    else $error("sequencer did not return to idle after the last byte");

  a_load_starts_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StSend)
    else $error("load did not start sending");

  a_no_load_and_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.emit))
    else $error("load and emit in the same cycle");

endmodule

`default_nettype wire

// File: design/wire_value_serializer.sv
// ----------------------------------------------------------------------------
// wire_value_serializer
// Encodes one value of up to 64 bits as fixed, bool, varint or zigzag varint
// wire bytes, least significant first, one byte per response.
// ----------------------------------------------------------------------------
// Flow: the request is loaded into the value register, then each emit moves
// one byte into the output register. Throughput: one byte per cycle while the
// consumer does not stall a waiting byte; a new request is taken only once the
// last byte of the current item has been emitted. A request with the unused
// selector is taken while idle and produces no bytes.
// Reset: asynchronous, active low; clears the sequencer and output valid.
`default_nettype none

module wire_value_serializer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire wvs_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wvs_pkg::out_rsp_t      out_rsp_o
);
  import wvs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_req_i.func),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wvs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// File: verif/wire_value_serializer_test.sv
// ----------------------------------------------------------------------------
// wire_value_serializer_test
// Drives encoding requests into the wire value serializer and checks every
// output byte and its last-byte mark against a local encoder, through phases
// with no idling, an idle sender, a stalling receiver and both at once.
// ----------------------------------------------------------------------------

module wire_value_serializer_test;

  timeunit 1ns;
  timeprecision 1ps;

  import wvs_pkg::*;

  localparam int unsigned ClkHalf    = 10;
  localparam int unsigned ResetLen   = 7;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 34;
  localparam int unsigned ReportMax  = 10;

  // Holds the bytes the serializer still owes, in wire order.
  class wire_byte_board;
    out_rsp_t    expected_bytes[$];
    int unsigned faults;

    function void add_expected(out_rsp_t b);
      expected_bytes = {expected_bytes, b};
    endfunction

    function void push_fixed(logic [ValueW-1:0] v, int unsigned nbytes);
      out_rsp_t b;
      for (int unsigned i = 0; i < nbytes; i++) begin
        b.out_byte = v[ByteW-1:0];
        b.last     = (i + 1 == nbytes);
        add_expected(b);
        v = v >> ByteW;
      end
    endfunction

    function void push_varint(logic [ValueW-1:0] v);
      out_rsp_t b;
      while (v >= 64'h80) begin
        b.out_byte = {1'b1, v[GroupW-1:0]};
        b.last     = 1'b0;
        add_expected(b);
        v = v >> GroupW;
      end
      b.out_byte = v[ByteW-1:0];
      b.last     = 1'b1;
      add_expected(b);
    endfunction

    function void note_request(in_req_t r);
      case (func_e'(r.func))
        FuncFixed8:  push_fixed(r.value, 1);
        FuncFixed16: push_fixed(r.value, 2);
        FuncFixed32: push_fixed(r.value, 4);
        FuncFixed64: push_fixed(r.value, 8);
        FuncBool:    push_fixed({63'd0, r.value != '0}, 1);
        FuncVarint:  push_varint(r.value);
        FuncZigzag:  push_varint((r.value << 1) ^ {ValueW{r.value[ValueW-1]}});
        default: begin
          // The unused selector produces no bytes at all.
        end
      endcase
    endfunction

    function void check_byte(out_rsp_t got);
      out_rsp_t want;
      if (expected_bytes.size() == 0) begin
        faults++;
        if (faults <= ReportMax)
          $display("%0t: unexpected byte %02h last %0b", $realtime, got.out_byte, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last) begin
        faults++;
        if (faults <= ReportMax)
          $display("%0t: byte expected %02h last %0b, got %02h last %0b", $realtime,
                   want.out_byte, want.last, got.out_byte, got.last);
      end
    endfunction

    function bit drained();
      return expected_bytes.size() == 0;
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  wire_byte_board byte_board = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  int unsigned    cycle_count   = 0;

  wire_value_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) byte_board.note_request(in_req_i);
    if (rst_ni && out_valid_o && !out_stall_i) byte_board.check_byte(out_rsp_o);
  end

  // Called at a rising edge; returns at the edge that takes the request.
  task automatic send_request(func_e f, logic [ValueW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_req_i.func  <= f;
    in_req_i.value <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Holds the sender off until every owed byte is out and the block is quiet.
  // The first wait lets the monitor note the request taken at this edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!byte_board.drained()) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic send_random_items(int unsigned count);
    logic [ValueW-1:0] v;
    func_e             f;
    int unsigned       w;
    for (int unsigned i = 0; i < count; i++) begin
      // Narrow values give short varints; inverting them gives negatives.
      w = $urandom_range(1, ValueW);
      v = {$urandom(), $urandom()};
      if (w < ValueW) v = v & ((64'd1 << w) - 64'd1);
      if ($urandom_range(3) == 0) v = ~v;
      if ($urandom_range(15) == 0) f = FuncUnused;
      else f = func_e'($urandom_range(FuncFixed8, FuncZigzag));
      send_request(f, v);
    end
  endtask

  initial begin
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, every encoding, wide values on fixed forms, zero varint.
    send_request(FuncFixed8,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncFixed8,  64'h0);
    send_request(FuncFixed16, 64'hDEAD_BEEF_CAFE_1234);
    send_request(FuncFixed32, 64'h0123_4567_89AB_CDEF);
    send_request(FuncFixed64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncFixed64, 64'h8000_0000_0000_0001);
    send_request(FuncBool,    64'h0);
    send_request(FuncBool,    64'h8000_0000_0000_0000);
    send_request(FuncBool,    64'h1);
    send_request(FuncVarint,  64'h0);
    send_request(FuncVarint,  64'h7F);
    send_request(FuncVarint,  64'h80);
    send_request(FuncVarint,  64'h3FFF);
    send_request(FuncVarint,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncVarint,  64'h8000_0000_0000_0000);
    send_request(FuncZigzag,  64'h0);
    send_request(FuncZigzag,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncZigzag,  64'h1);
    send_request(FuncZigzag,  64'h8000_0000_0000_0000);
    send_request(FuncZigzag,  64'h7FFF_FFFF_FFFF_FFFF);
    send_request(FuncUnused,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncUnused,  64'h0);
    send_request(FuncFixed8,  64'h5A);
    drain();

    send_random_items(PhaseItems);
    drain();

    send_idle_pct = 78;
    send_random_items(PhaseItems);
    drain();

    send_idle_pct = 0;
    stall_pct     = 78;
    send_random_items(PhaseItems);
    drain();

    send_idle_pct = 29;
    stall_pct     = 29;
    send_random_items(PhaseItems);
    drain();

    if (byte_board.faults == 0 && byte_board.drained()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
design/wvs_pkg.sv
design/wvs_datapath.sv
design/wvs_ctrl.sv
design/wire_value_serializer.sv
verif/wire_value_serializer_test.sv
